// ===== sv/sbq_pkg.sv =====
// Shared definitions for the segmented byte queue: sizes, action codes,
// result and memory-request structs, and the pointer wrap function.
// No dependencies.
package sbq_pkg;

    // Store and request sizing
    localparam int STORE_DEPTH = 1024;
    localparam int MAX_REQUEST = 64;
    localparam int PTR_W       = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
    localparam int REQ_W       = 7;
    localparam int BYTE_W      = 8;
    localparam int ENTRY_W     = BYTE_W + 1;
    localparam int SUM_W       = CNT_W + REQ_W;

    // Stream packing
    localparam int IN_TDATA_W    = ((BYTE_W + REQ_W + 7) / 8) * 8;
    localparam int OUT_PAYLOAD_W = BYTE_W + 2 * CNT_W;
    localparam int OUT_TDATA_W   = ((OUT_PAYLOAD_W + 7) / 8) * 8;
    localparam int OUT_TUSER_W   = 2;
    localparam int TUSER_VALID   = 0;
    localparam int TUSER_REFUSED = 1;

    typedef enum logic [1:0] {
        ACT_ENQUEUE = 2'd0,
        ACT_DEQUEUE = 2'd1,
        ACT_PEEK    = 2'd2,
        ACT_DROP    = 2'd3
    } t_action;

    // One result item as produced by the sequencer
    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              byte_valid;
        logic              last;
        logic              refused;
        logic [CNT_W-1:0]  bytes_queued;
        logic [CNT_W-1:0]  buffers_queued;
    } t_result;

    // Write and read request toward the byte store
    typedef struct packed {
        logic               we;
        logic [PTR_W-1:0]   waddr;
        logic [ENTRY_W-1:0] wdata;
        logic               re;
        logic [PTR_W-1:0]   raddr;
    } t_mem_req;

    // Advance a store pointer with wrap at the last entry
    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(STORE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

endpackage

// ===== sv/sbq_store.sv =====
// Single-port-write, single-port-read synchronous RAM for the byte store.
// Read data is registered and holds until the next read. No dependencies.
module sbq_store #(
    parameter int DEPTH  = 1024,
    parameter int WIDTH  = 9,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/sbq_seq.sv =====
// Sequencer of the segmented byte queue: pointers, byte and buffer counts,
// request walk over the store with one read in flight per result.
// Depends on sbq_pkg.
module sbq_seq (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  sbq_pkg::t_action           i_action,
    input  logic [sbq_pkg::BYTE_W-1:0] i_data_byte,
    input  logic                       i_ends_buffer,
    input  logic [sbq_pkg::REQ_W-1:0]  i_request_count,
    input  logic                       i_out_free,
    output sbq_pkg::t_mem_req          o_mem,
    input  logic [sbq_pkg::ENTRY_W-1:0] i_rd_data,
    output logic                       o_res_valid,
    output sbq_pkg::t_result           o_res
);
    import sbq_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_MOVE
    } t_state;

    t_state           r_state;
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W-1:0] r_cur;
    logic [CNT_W-1:0] r_bytes;
    logic [CNT_W-1:0] r_bufs;
    logic [REQ_W-1:0] r_issue;
    logic [REQ_W-1:0] r_left;
    logic             r_give;
    logic             r_take;
    logic             r_pend;

    logic             accept;
    logic             is_enq;
    logic             full;
    logic             store_wr;
    logic [REQ_W-1:0] req_sat;
    logic [REQ_W-1:0] req_fit;
    logic             load;
    logic             issue;
    logic [CNT_W-1:0] n_bytes;
    logic [CNT_W-1:0] n_bufs;

    // Accept only when idle and the result slot can take an immediate result
    assign o_in_ready = (r_state == S_IDLE) && i_out_free;

    // Decode the incoming item and size the request
    always_comb begin
        accept   = i_in_valid && o_in_ready;
        is_enq   = (i_action == ACT_ENQUEUE);
        full     = (r_bytes == CNT_W'(STORE_DEPTH));
        store_wr = accept && is_enq && !full;
        req_sat  = (i_request_count > REQ_W'(MAX_REQUEST)) ? REQ_W'(MAX_REQUEST)
                                                            : i_request_count;
        req_fit  = (SUM_W'(r_bytes) < SUM_W'(req_sat)) ? REQ_W'(r_bytes) : req_sat;
    end

    // Walk control: drain read data into the result slot, keep one read ahead
    always_comb begin
        load  = (r_state == S_MOVE) && r_pend && i_out_free;
        issue = (r_state == S_MOVE) && (r_issue != '0) && (!r_pend || load);
    end

    // Next counts for the result being produced this cycle
    always_comb begin
        n_bytes = r_bytes;
        n_bufs  = r_bufs;
        if (store_wr) begin
            n_bytes = r_bytes + 1'b1;
            n_bufs  = r_bufs + CNT_W'(i_ends_buffer);
        end else if (load && r_take) begin
            n_bytes = r_bytes - 1'b1;
            if (i_rd_data[BYTE_W] && (r_bufs != '0)) begin
                n_bufs = r_bufs - 1'b1;
            end
        end
    end

    // Store requests
    always_comb begin
        o_mem.we    = store_wr;
        o_mem.waddr = r_wr_ptr;
        o_mem.wdata = {i_ends_buffer, i_data_byte};
        o_mem.re    = issue;
        o_mem.raddr = r_cur;
    end

    // Result toward the output register
    always_comb begin
        o_res_valid          = load || (accept && (is_enq || (req_fit == '0)));
        o_res.out_byte       = (load && r_give) ? i_rd_data[BYTE_W-1:0] : '0;
        o_res.byte_valid     = load && r_give;
        o_res.last           = load ? (r_left == REQ_W'(1)) : 1'b1;
        o_res.refused        = accept && is_enq && full;
        o_res.bytes_queued   = n_bytes;
        o_res.buffers_queued = n_bufs;
    end

    // State, pointers and counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cur    <= '0;
            r_bytes  <= '0;
            r_bufs   <= '0;
            r_issue  <= '0;
            r_left   <= '0;
            r_give   <= 1'b0;
            r_take   <= 1'b0;
            r_pend   <= 1'b0;
        end else begin
            r_bytes <= n_bytes;
            r_bufs  <= n_bufs;
            r_pend  <= issue || (r_pend && !load);
            if (store_wr) begin
                r_wr_ptr <= ptr_next(r_wr_ptr);
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept && !is_enq && (req_fit != '0)) begin
                        r_state <= S_MOVE;
                        r_issue <= req_fit;
                        r_left  <= req_fit;
                        r_cur   <= r_rd_ptr;
                        r_give  <= (i_action == ACT_DEQUEUE) || (i_action == ACT_PEEK);
                        r_take  <= (i_action == ACT_DEQUEUE) || (i_action == ACT_DROP);
                    end
                end
                S_MOVE: begin
                    if (issue) begin
                        r_cur   <= ptr_next(r_cur);
                        r_issue <= r_issue - 1'b1;
                    end
                    if (load) begin
                        r_left <= r_left - 1'b1;
                        // final byte: commit the read pointer for removals
                        if (r_left == REQ_W'(1)) begin
                            r_state <= S_IDLE;
                            if (r_take) begin
                                r_rd_ptr <= r_cur;
                            end
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== sv/segmented_byte_queue.sv =====
// Segmented byte queue, top level: stream ports, byte store and output register.
// Depends on sbq_pkg, sbq_store and sbq_seq.
//
// A queue of up to STORE_DEPTH bytes that remembers where each enqueued buffer
// ended. An enqueue gives one result; into a full store it is refused and
// flagged. A dequeue, peek or drop of N bytes (N capped at MAX_REQUEST and at
// the bytes held) gives N results, one per cycle while the output is taken.
// The first of them reaches the output register once the sequencer has
// entered its walk state and issued the read and the store has registered the
// read data. A request that moves nothing gives a single result at once. The
// single read port of the byte store sets the rate of the walk. Items are
// handled one at a time: the next item is taken once the last result of the
// current one sits in the output register and the output register is free.
// Every result carries the byte and buffer counts after it. The store needs no
// clearing after reset, so the block is ready at once.
module segmented_byte_queue (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [7:0] data_byte, [14:8] request_count, rest zero
    input  logic [sbq_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // ends_buffer
    input  logic                                s_axis_tlast,
    // [1:0] action
    input  logic [1:0]                          s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [7:0] out_byte, [18:8] bytes_queued, [29:19] buffers_queued, rest zero
    output logic [sbq_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // last
    output logic                                m_axis_tlast,
    // [0] byte_valid, [1] refused
    output logic [sbq_pkg::OUT_TUSER_W-1:0]     m_axis_tuser
);
    import sbq_pkg::*;

    t_mem_req           mem_req;
    logic [ENTRY_W-1:0] rd_data;
    logic               res_valid;
    t_result            res;
    logic               out_free;
    logic               r_out_valid;
    t_result            r_out;

    assign out_free = !r_out_valid || m_axis_tready;

    sbq_seq u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (s_axis_tvalid),
        .o_in_ready      (s_axis_tready),
        .i_action        (t_action'(s_axis_tuser)),
        .i_data_byte     (s_axis_tdata[BYTE_W-1:0]),
        .i_ends_buffer   (s_axis_tlast),
        .i_request_count (s_axis_tdata[BYTE_W +: REQ_W]),
        .i_out_free      (out_free),
        .o_mem           (mem_req),
        .i_rd_data       (rd_data),
        .o_res_valid     (res_valid),
        .o_res           (res)
    );

    sbq_store #(
        .DEPTH (STORE_DEPTH),
        .WIDTH (ENTRY_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_req.we),
        .i_waddr (mem_req.waddr),
        .i_wdata (mem_req.wdata),
        .i_re    (mem_req.re),
        .i_raddr (mem_req.raddr),
        .o_rdata (rd_data)
    );

    // Output register: load a new result, drop the flag once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out <= res;
        end
    end

    // Pack the result onto the master side
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_TDATA_W'({r_out.buffers_queued, r_out.bytes_queued,
                                         r_out.out_byte});
    assign m_axis_tlast  = r_out.last;
    always_comb begin
        m_axis_tuser                = '0;
        m_axis_tuser[TUSER_VALID]   = r_out.byte_valid;
        m_axis_tuser[TUSER_REFUSED] = r_out.refused;
    end

endmodule

// ===== sv/sbq_checker.sv =====
// Port-level checks for the segmented byte queue, bound to the top level.
// Depends on sbq_pkg and segmented_byte_queue.
module sbq_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [sbq_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                            m_axis_tlast,
    input logic [sbq_pkg::OUT_TUSER_W-1:0] m_axis_tuser
);
    import sbq_pkg::*;

    logic [CNT_W-1:0] bytes_q;
    logic [CNT_W-1:0] bufs_q;

    assign bytes_q = m_axis_tdata[BYTE_W +: CNT_W];
    assign bufs_q  = m_axis_tdata[BYTE_W + CNT_W +: CNT_W];

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
            && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // A refusal is a lone closing result without data
    a_refused_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[TUSER_REFUSED] |->
            m_axis_tlast && !m_axis_tuser[TUSER_VALID])
        else $error("refused result malformed");

    // Byte count never exceeds the store
    a_bytes_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (bytes_q <= CNT_W'(STORE_DEPTH)))
        else $error("byte count above store depth");

    // Every counted buffer still holds its end byte
    a_bufs_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (bufs_q <= bytes_q))
        else $error("buffer count above byte count");

    // No new item is taken while a multi-result request is still open
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |-> !s_axis_tready)
        else $error("input accepted inside a request");

endmodule

bind segmented_byte_queue sbq_checker u_sbq_checker (.*);
